FILE: design/scoped_symbol_table_unit_assert.svh
// Assertion macros for the scoped symbol table unit.
// Used by scoped_symbol_table_unit.sv; expects clk and rst_n in scope.
`ifndef SCOPED_SYMBOL_TABLE_UNIT_ASSERT_SVH
`define SCOPED_SYMBOL_TABLE_UNIT_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define SST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

FILE: design/sst_pkg.sv
// Package for the scoped symbol table unit: payload types, opcodes and status codes.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package sst_pkg;

    typedef logic [1:0]  opcode_t;
    typedef logic [2:0]  status_t;
    typedef logic [31:0] word_t;

    localparam opcode_t OP_SET  = 2'd0;
    localparam opcode_t OP_GET  = 2'd1;
    localparam opcode_t OP_PUSH = 2'd2;
    localparam opcode_t OP_POP  = 2'd3;

    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_VALUE_FULL = 3'd1;
    localparam status_t ST_SHADOW     = 3'd2;
    localparam status_t ST_SCOPE_FULL = 3'd3;
    localparam status_t ST_BASE_POP   = 3'd4;

endpackage

FILE: design/sst_req_if.sv
// Request channel of the scoped symbol table unit (valid/ready plus payload).
// Depends on sst_pkg.
`timescale 1ns / 1ps

interface sst_req_if;
    logic            valid;
    logic            ready;
    sst_pkg::opcode_t opcode;
    sst_pkg::word_t   symbol_key;
    sst_pkg::word_t   value_in;

    modport source (output valid, output opcode, output symbol_key, output value_in,
                    input ready);
    modport sink   (input valid, input opcode, input symbol_key, input value_in,
                    output ready);
endinterface

FILE: design/sst_rsp_if.sv
// Response channel of the scoped symbol table unit (valid/ready plus payload).
// Depends on sst_pkg.
`timescale 1ns / 1ps

interface sst_rsp_if;
    logic             valid;
    logic             ready;
    logic             found;
    sst_pkg::word_t   value_out;
    sst_pkg::status_t status;

    modport source (output valid, output found, output value_out, output status,
                    input ready);
    modport sink   (input valid, input found, input value_out, input status,
                    output ready);
endinterface

FILE: design/scoped_symbol_table_unit.sv
// Scoped symbol table unit: top level with sequencer, stores and output register.
// Depends on sst_pkg, sst_req_if, sst_rsp_if and scoped_symbol_table_unit_assert.svh.
//
// Usage:
//   req carries one operation per transfer: set, get, push scope or pop scope.
//   rsp returns exactly one result per request: found, value_out and status.
//   One request is worked on at a time; req.ready is low while it is in flight.
//   Set and get scan the symbol slots with one shared key comparator, a read
//   state and a compare state per slot, stopping at the first hit. Push and a
//   refused push or pop finish in the dispatch state. Pop unwinds one binding
//   per pass through its loop, owner and count states, then restores the mark.
//   After reset a clearing pass over all slots zeroes the per-slot binding
//   counts; req.ready stays low during it.
//   Results sit in an output register; a new request is taken while the
//   previous result is being transferred, and held off while rsp stalls.
`timescale 1ns / 1ps
`include "scoped_symbol_table_unit_assert.svh"

module scoped_symbol_table_unit #(
    parameter int VALUE_DEPTH = 64,
    parameter int SCOPE_DEPTH = 16,
    parameter int MAX_SHADOW  = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    sst_req_if.sink   req,
    sst_rsp_if.source rsp
);

    localparam int VIW   = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;
    localparam int TW    = $clog2(VALUE_DEPTH + 1);
    localparam int SIW   = (SCOPE_DEPTH > 1) ? $clog2(SCOPE_DEPTH) : 1;
    localparam int STW   = $clog2(SCOPE_DEPTH + 1);
    localparam int CW    = $clog2(MAX_SHADOW + 1);
    localparam int PDEPTH = VALUE_DEPTH * MAX_SHADOW;
    localparam int PAW   = $clog2(PDEPTH);
    localparam int DW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

    // Sequencer states.
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_SRD   = 4'd3;
    localparam logic [3:0] S_SCMP  = 4'd4;
    localparam logic [3:0] S_FOUND = 4'd5;
    localparam logic [3:0] S_PRD   = 4'd6;
    localparam logic [3:0] S_NEW   = 4'd7;
    localparam logic [3:0] S_GVAL  = 4'd8;
    localparam logic [3:0] S_PLOOP = 4'd9;
    localparam logic [3:0] S_POWN  = 4'd10;
    localparam logic [3:0] S_PCNT  = 4'd11;
    localparam logic [3:0] S_PMARK = 4'd12;

    // Stores.
    logic [DW-1:0]  value_mem [VALUE_DEPTH];
    logic [VIW-1:0] owner_mem [VALUE_DEPTH];
    logic [31:0]    key_mem   [VALUE_DEPTH];
    logic [CW-1:0]  count_mem [VALUE_DEPTH];
    logic [VIW-1:0] pos_mem   [PDEPTH];
    logic [TW-1:0]  mark_mem  [SCOPE_DEPTH];

    logic [DW-1:0]  value_q;
    logic [VIW-1:0] owner_q;
    logic [31:0]    key_q;
    logic [CW-1:0]  count_q;
    logic [VIW-1:0] pos_q;
    logic [TW-1:0]  mark_q;

    // Store ports.
    logic           value_we;
    logic [VIW-1:0] value_waddr, value_raddr;
    logic [DW-1:0]  value_wdata;
    logic           owner_we;
    logic [VIW-1:0] owner_addr;
    logic           key_we;
    logic [VIW-1:0] key_addr;
    logic           count_we;
    logic [VIW-1:0] count_waddr, count_raddr;
    logic [CW-1:0]  count_wdata;
    logic           pos_we;
    logic [PAW-1:0] pos_waddr, pos_raddr;
    logic           mark_we;
    logic [SIW-1:0] mark_waddr, mark_raddr;

    // Control and working registers.
    logic [3:0]     state_reg, state_next;
    logic [VIW-1:0] idx_reg, idx_next;
    logic           hit_reg, hit_next;
    logic           free_ok_reg, free_ok_next;
    logic [VIW-1:0] slot_reg, slot_next;
    logic [VIW-1:0] free_reg, free_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [TW-1:0]  top_reg, top_next;
    logic [STW-1:0] stop_reg, stop_next;
    logic [TW-1:0]  mark_reg, mark_next;
    logic [VIW-1:0] own_reg, own_next;
    logic           ov_reg, ov_next;

    // Payload registers.
    sst_pkg::opcode_t op_reg;
    logic [31:0]      key_reg;
    logic [DW-1:0]    val_reg;
    logic             found_reg, found_next;
    logic [31:0]      vout_reg, vout_next;
    sst_pkg::status_t status_reg, status_next;

    logic           fin;
    logic           accept;
    logic [TW-1:0]  top_m1;
    logic [STW-1:0] stop_m2;
    logic [PAW-1:0] pos_base;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && (!ov_reg || rsp.ready);
    assign rsp.valid  = ov_reg;
    assign rsp.found  = found_reg;
    assign rsp.value_out = vout_reg;
    assign rsp.status = status_reg;

    assign top_m1   = top_reg - TW'(1);
    assign stop_m2  = stop_reg - STW'(2);
    assign pos_base = PAW'(slot_reg) * PAW'(MAX_SHADOW);

    // Memories: one write port each, registered read.
    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            value_mem[value_waddr] <= value_wdata;
        end
        value_q <= value_mem[value_raddr];
        if (owner_we)
        begin
            owner_mem[owner_addr] <= slot_reg;
        end
        owner_q <= owner_mem[owner_addr];
        if (key_we)
        begin
            key_mem[key_addr] <= key_reg;
        end
        key_q <= key_mem[key_addr];
        if (count_we)
        begin
            count_mem[count_waddr] <= count_wdata;
        end
        count_q <= count_mem[count_raddr];
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= top_reg[VIW-1:0];
        end
        pos_q <= pos_mem[pos_raddr];
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= top_reg;
        end
        mark_q <= mark_mem[mark_raddr];
    end

    // Sequencer next-state and store control.
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        free_ok_next = free_ok_reg;
        slot_next    = slot_reg;
        free_next    = free_reg;
        cnt_next     = cnt_reg;
        top_next     = top_reg;
        stop_next    = stop_reg;
        mark_next    = mark_reg;
        own_next     = own_reg;
        fin          = 1'b0;
        found_next   = 1'b0;
        vout_next    = '0;
        status_next  = sst_pkg::ST_OK;

        value_we    = 1'b0;
        value_waddr = top_reg[VIW-1:0];
        value_wdata = val_reg;
        value_raddr = pos_q;
        owner_we    = 1'b0;
        owner_addr  = top_m1[VIW-1:0];
        key_we      = 1'b0;
        key_addr    = idx_reg;
        count_we    = 1'b0;
        count_waddr = idx_reg;
        count_wdata = '0;
        count_raddr = idx_reg;
        pos_we      = 1'b0;
        pos_waddr   = pos_base + PAW'(cnt_reg);
        pos_raddr   = pos_base + PAW'(cnt_reg) - PAW'(1);
        mark_we     = 1'b0;
        mark_waddr  = stop_reg[SIW-1:0];
        mark_raddr  = stop_m2[SIW-1:0];

        case (state_reg)
            S_CLR:
            begin
                count_we = 1'b1;
                if (idx_reg == VIW'(VALUE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                idx_next = idx_reg + VIW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                idx_next     = '0;
                hit_next     = 1'b0;
                free_ok_next = 1'b0;
                cnt_next     = '0;
                case (op_reg)
                    sst_pkg::OP_PUSH:
                    begin
                        fin        = 1'b1;
                        state_next = S_IDLE;
                        if (stop_reg == STW'(SCOPE_DEPTH))
                        begin
                            status_next = sst_pkg::ST_SCOPE_FULL;
                        end
                        else
                        begin
                            mark_we   = 1'b1;
                            mark_next = top_reg;
                            stop_next = stop_reg + STW'(1);
                        end
                    end
                    sst_pkg::OP_POP:
                    begin
                        if (stop_reg <= STW'(1))
                        begin
                            fin         = 1'b1;
                            status_next = sst_pkg::ST_BASE_POP;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_PLOOP;
                        end
                    end
                    default:
                    begin
                        state_next = S_SRD;
                    end
                endcase
            end
            S_SRD:
            begin
                // Addresses for this slot go out on key_addr and count_raddr.
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                // Shared comparator: one slot key against the request key.
                if (count_q != '0 && key_q == key_reg)
                begin
                    hit_next   = 1'b1;
                    slot_next  = idx_reg;
                    cnt_next   = count_q;
                    state_next = S_FOUND;
                end
                else
                begin
                    if (count_q == '0 && !free_ok_reg)
                    begin
                        free_ok_next = 1'b1;
                        free_next    = idx_reg;
                    end
                    if (idx_reg == VIW'(VALUE_DEPTH - 1))
                    begin
                        state_next = S_FOUND;
                    end
                    else
                    begin
                        idx_next   = idx_reg + VIW'(1);
                        state_next = S_SRD;
                    end
                end
            end
            S_FOUND:
            begin
                if (hit_reg)
                begin
                    state_next = S_PRD;
                end
                else if (op_reg == sst_pkg::OP_GET)
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    slot_next  = free_reg;
                    state_next = S_NEW;
                end
            end
            S_PRD:
            begin
                // pos_q holds the innermost stack position of the symbol.
                if (op_reg == sst_pkg::OP_GET)
                begin
                    state_next = S_GVAL;
                end
                else if (TW'(pos_q) >= mark_reg)
                begin
                    value_we    = 1'b1;
                    value_waddr = pos_q;
                    fin         = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_NEW;
                end
            end
            S_NEW:
            begin
                // New shadowing binding on top of the value stack.
                fin        = 1'b1;
                state_next = S_IDLE;
                if (top_reg == TW'(VALUE_DEPTH))
                begin
                    status_next = sst_pkg::ST_VALUE_FULL;
                end
                else if (hit_reg && cnt_reg >= CW'(MAX_SHADOW))
                begin
                    status_next = sst_pkg::ST_SHADOW;
                end
                else if (!hit_reg && !free_ok_reg)
                begin
                    status_next = sst_pkg::ST_VALUE_FULL;
                end
                else
                begin
                    value_we    = 1'b1;
                    owner_we    = 1'b1;
                    owner_addr  = top_reg[VIW-1:0];
                    key_we      = !hit_reg;
                    key_addr    = slot_reg;
                    pos_we      = 1'b1;
                    count_we    = 1'b1;
                    count_waddr = slot_reg;
                    count_wdata = cnt_reg + CW'(1);
                    top_next    = top_reg + TW'(1);
                end
            end
            S_GVAL:
            begin
                fin        = 1'b1;
                found_next = 1'b1;
                vout_next  = 32'(value_q);
                state_next = S_IDLE;
            end
            S_PLOOP:
            begin
                // Unwind one binding per pass, or close the scope.
                if (top_reg > mark_reg)
                begin
                    state_next = S_POWN;
                end
                else
                begin
                    stop_next  = stop_reg - STW'(1);
                    state_next = S_PMARK;
                end
            end
            S_POWN:
            begin
                own_next    = owner_q;
                count_raddr = owner_q;
                state_next  = S_PCNT;
            end
            S_PCNT:
            begin
                if (count_q != '0)
                begin
                    count_we    = 1'b1;
                    count_waddr = own_reg;
                    count_wdata = count_q - CW'(1);
                end
                top_next   = top_m1;
                state_next = S_PLOOP;
            end
            S_PMARK:
            begin
                // The base scope mark is always zero.
                mark_next  = (stop_reg == STW'(1)) ? '0 : mark_q;
                fin        = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            ov_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            free_ok_reg <= 1'b0;
            top_reg     <= '0;
            stop_reg    <= STW'(1);
            mark_reg    <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            hit_reg     <= hit_next;
            free_ok_reg <= free_ok_next;
            top_reg     <= top_next;
            stop_reg    <= stop_next;
            mark_reg    <= mark_next;
            ov_reg      <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        free_reg <= free_next;
        cnt_reg  <= cnt_next;
        own_reg  <= own_next;
        if (accept)
        begin
            op_reg  <= req.opcode;
            key_reg <= req.symbol_key;
            val_reg <= req.value_in[DW-1:0];
        end
        if (fin)
        begin
            found_reg  <= found_next;
            vout_reg   <= vout_next;
            status_reg <= status_next;
        end
    end

    // Checks.
    `SST_ASSERT_ALWAYS(a_top_range, top_reg <= TW'(VALUE_DEPTH), "value stack overrun")
    `SST_ASSERT_ALWAYS(a_scope_range, (stop_reg - STW'(1)) < STW'(SCOPE_DEPTH), "scope overrun")
    `SST_ASSERT_ALWAYS(a_found_ok, ov_reg && found_reg |-> status_reg == sst_pkg::ST_OK, "found error")
    `SST_ASSERT_NEXT(a_accept_disp, accept, state_reg == S_DISP, "accepted request not dispatched")

endmodule

FILE: dv/scoped_symbol_table_unit_tb.sv
// Self-checking testbench for the scoped symbol table unit: directed table and stack-limit runs, then random traffic.
// Depends on sst_pkg, sst_req_if, sst_rsp_if and the scoped_symbol_table_unit top level.
`timescale 1ns / 1ps

module scoped_symbol_table_unit_tb;

    localparam int VDEPTH   = 64;
    localparam int SDEPTH   = 16;
    localparam int SHADOW   = 4;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        sst_pkg::opcode_t op;
        sst_pkg::word_t   key;
        sst_pkg::word_t   val;
    } request_t;

    typedef struct packed {
        logic             found;
        sst_pkg::word_t   value;
        sst_pkg::status_t status;
    } answer_t;

    // A directed row: the request and, when known at a glance, the answer.
    typedef struct packed {
        request_t req;
        logic     typed;
        answer_t  ans;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sst_req_if req_ch ();
    sst_rsp_if rsp_ch ();

    scoped_symbol_table_unit u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch.sink),
        .rsp  (rsp_ch.source)
    );

    always #2 clk = ~clk;

    // Predictor state: binding stack, scope marks and per-symbol slots.
    sst_pkg::word_t bind_value [VDEPTH];
    int             bind_owner [VDEPTH];
    int             bind_top;
    int             scope_mark [SDEPTH];
    int             scope_open;
    sst_pkg::word_t sym_key    [VDEPTH];
    bit             sym_live   [VDEPTH];
    int             sym_depth  [VDEPTH];
    int             sym_pos    [VDEPTH][SHADOW];

    answer_t pending_answers[$];
    logic    pending_typed[$];
    answer_t pending_typed_ans[$];
    int      error_count = 0;
    int      idle_cycles = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    function automatic int lookup_symbol(sst_pkg::word_t key);
        for (int i = 0; i < VDEPTH; i++)
            if (sym_live[i] && sym_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int innermost_pos(int s);
        return sym_pos[s][sym_depth[s] - 1];
    endfunction

    // Applies one request to the predictor state and returns the answer.
    function automatic answer_t apply_request(request_t r);
        answer_t a;
        int s;
        int mark;
        a = '0;
        a.status = sst_pkg::ST_OK;
        case (r.op)
            sst_pkg::OP_SET:
            begin
                s = lookup_symbol(r.key);
                mark = scope_mark[scope_open - 1];
                if (s >= 0 && sym_depth[s] > 0 && innermost_pos(s) >= mark)
                    bind_value[innermost_pos(s)] = r.val;
                else if (bind_top >= VDEPTH)
                    a.status = sst_pkg::ST_VALUE_FULL;
                else if (s >= 0 && sym_depth[s] >= SHADOW)
                    a.status = sst_pkg::ST_SHADOW;
                else
                begin
                    if (s < 0)
                    begin
                        for (int i = 0; i < VDEPTH; i++)
                            if (!sym_live[i])
                            begin
                                s = i;
                                break;
                            end
                        sym_live[s] = 1'b1;
                        sym_key[s] = r.key;
                        sym_depth[s] = 0;
                    end
                    bind_value[bind_top] = r.val;
                    bind_owner[bind_top] = s;
                    sym_pos[s][sym_depth[s]] = bind_top;
                    sym_depth[s]++;
                    bind_top++;
                end
            end
            sst_pkg::OP_GET:
            begin
                s = lookup_symbol(r.key);
                if (s >= 0 && sym_depth[s] > 0)
                begin
                    a.found = 1'b1;
                    a.value = bind_value[innermost_pos(s)];
                end
            end
            sst_pkg::OP_PUSH:
            begin
                if (scope_open >= SDEPTH)
                    a.status = sst_pkg::ST_SCOPE_FULL;
                else
                begin
                    scope_mark[scope_open] = bind_top;
                    scope_open++;
                end
            end
            default:
            begin
                if (scope_open <= 1)
                    a.status = sst_pkg::ST_BASE_POP;
                else
                begin
                    mark = scope_mark[scope_open - 1];
                    while (bind_top > mark)
                    begin
                        s = bind_owner[bind_top - 1];
                        sym_depth[s]--;
                        if (sym_depth[s] == 0)
                            sym_live[s] = 1'b0;
                        bind_top--;
                    end
                    scope_open--;
                end
            end
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Drives one transfer on the request channel; the answer is queued on acceptance.
    // Returns at the falling edge after the transfer with valid still high.
    task automatic send_request(request_t r, logic typed, answer_t typed_ans);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= r.op;
        req_ch.symbol_key <= r.key;
        req_ch.value_in <= r.val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_answers.push_back(apply_request(r));
        pending_typed.push_back(typed);
        pending_typed_ans.push_back(typed_ans);
        @(negedge clk);
    endtask

    // Result checker and watchdog, both on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    report_mismatch("result count", 64'(1), 64'(0));
                end
                else
                begin
                    answer_t want;
                    logic typed;
                    answer_t typed_ans;
                    want = pending_answers.pop_front();
                    typed = pending_typed.pop_front();
                    typed_ans = pending_typed_ans.pop_front();
                    if (typed && typed_ans != want)
                        report_mismatch("directed table entry", 64'(typed_ans), 64'(want));
                    if (rsp_ch.found !== want.found)
                        report_mismatch("found", 64'(rsp_ch.found), 64'(want.found));
                    if (rsp_ch.value_out !== want.value)
                        report_mismatch("value_out", 64'(rsp_ch.value_out), 64'(want.value));
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
                end
            end
            if (idle_cycles >= WATCHDOG)
            begin
                $display("** scoped_symbol_table_unit: FAILED **");
                $finish;
            end
        end
    end

    // Receiver stalls, drawn at the falling edge.
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic row_t mk(sst_pkg::opcode_t op, sst_pkg::word_t key,
                                sst_pkg::word_t val, logic typed, logic found,
                                sst_pkg::word_t value, sst_pkg::status_t status);
        row_t r;
        r.req = '{op: op, key: key, val: val};
        r.typed = typed;
        r.ans = '{found: found, value: value, status: status};
        return r;
    endfunction

    // Draws a key from a small pool so sets, gets and shadowing collide often.
    function automatic sst_pkg::word_t pick_key(int pool);
        if ($urandom_range(19) == 0)
            return $urandom();
        return 32'hA5A5_0000 ^ sst_pkg::word_t'($urandom_range(pool - 1));
    endfunction

    function automatic request_t random_request(int phase);
        request_t r;
        int pick;
        int pool;
        pool = (phase == 1) ? 80 : 12;
        pick = $urandom_range(99);
        r.key = pick_key(pool);
        r.val = $urandom();
        if (pick < 45)
            r.op = sst_pkg::OP_SET;
        else if (pick < 75)
            r.op = sst_pkg::OP_GET;
        else if (pick < 88)
            r.op = sst_pkg::OP_PUSH;
        else
            r.op = sst_pkg::OP_POP;
        // Stacks fill in the middle phase, drain in the others.
        if (phase != 1 && r.op == sst_pkg::OP_PUSH && $urandom_range(1))
            r.op = sst_pkg::OP_POP;
        return r;
    endfunction

    initial
    begin
        row_t table_rows[$];
        request_t r;
        req_ch.valid = 1'b0;
        req_ch.opcode = sst_pkg::OP_GET;
        req_ch.symbol_key = '0;
        req_ch.value_in = '0;
        bind_top = 0;
        scope_open = 1;
        foreach (scope_mark[i]) scope_mark[i] = 0;
        foreach (sym_live[i])
        begin
            sym_live[i] = 1'b0;
            sym_depth[i] = 0;
        end

        // After reset, extremes, shadowing and the base scope.
        table_rows.push_back(mk(sst_pkg::OP_GET, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_POP, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0,
                                sst_pkg::ST_BASE_POP));
        table_rows.push_back(mk(sst_pkg::OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0,
                                32'h0, sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1,
                                32'hFFFF_FFFF, sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_SET, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_SET, 32'h0, 32'h1234_5678, 1'b1, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_PUSH, 32'h0, 32'h0, 1'b1, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_SET, 32'h0, 32'h5555_AAAA, 1'b0, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_PUSH, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_SET, 32'h0, 32'hAAAA_5555, 1'b0, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_PUSH, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_SET, 32'h0, 32'h0000_0001, 1'b0, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_PUSH, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_SET, 32'h0, 32'h8000_0000, 1'b1, 1'b0, 32'h0,
                                sst_pkg::ST_SHADOW));
        table_rows.push_back(mk(sst_pkg::OP_GET, 32'h0, 32'h0, 1'b1, 1'b1, 32'h0000_0001,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_POP, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_POP, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_GET, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_POP, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_POP, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0,
                                sst_pkg::ST_OK));
        table_rows.push_back(mk(sst_pkg::OP_GET, 32'h0, 32'h0, 1'b1, 1'b1, 32'h1234_5678,
                                sst_pkg::ST_OK));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (table_rows[i])
            send_request(table_rows[i].req, table_rows[i].typed, table_rows[i].ans);

        // Scope stack to its limit and back to the base scope.
        for (int i = 0; i < SDEPTH + 1; i++)
            send_request('{op: sst_pkg::OP_PUSH, key: '0, val: '0}, 1'b0, '0);
        for (int i = 0; i < SDEPTH + 1; i++)
            send_request('{op: sst_pkg::OP_POP, key: '0, val: '0}, 1'b0, '0);

        // Value stack to its limit with distinct keys, then three more new bindings.
        send_request('{op: sst_pkg::OP_PUSH, key: '0, val: '0}, 1'b0, '0);
        for (int i = 0; i < VDEPTH + 1; i++)
            send_request('{op: sst_pkg::OP_SET, key: 32'h7000_0000 + i, val: $urandom()},
                         1'b0, '0);
        send_request('{op: sst_pkg::OP_POP, key: '0, val: '0}, 1'b0, '0);

        // Hold off until every expected result has come.
        req_ch.valid <= 1'b0;
        wait (pending_answers.size() == 0);
        @(negedge clk);

        // Random traffic in three idling phases.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 85 : 0;
            recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 9 : 0;
            for (int n = 0; n < 420; n++)
            begin
                r = random_request(phase);
                send_request(r, 1'b0, '0);
            end
        end
        req_ch.valid <= 1'b0;
        recv_idle_pct = 0;

        wait (pending_answers.size() == 0);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("** scoped_symbol_table_unit: PASSED **");
        else
            $display("** scoped_symbol_table_unit: FAILED **");
        $finish;
    end

endmodule
